### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the record stack rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising clock edge, off while in reset
`define VLRS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication, sampled on the rising clock edge, off while in reset
`define VLRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on the rising clock edge, off while in reset
`define VLRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/vlrs_pkg.sv
// ----------------------------------------------------------------------------
// vlrs_pkg
// types and fixed widths of the variable-length record stack
// ----------------------------------------------------------------------------
package vlrs_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned STAT_W  = 3;
	localparam int unsigned FILL_W  = 11;
	localparam int unsigned TLEN_W  = 7;
	localparam int unsigned CAP_W   = 11;
	localparam int unsigned TDATA_W = 32;
	localparam int unsigned PAD_W   = TDATA_W - BYTE_W - STAT_W - FILL_W - TLEN_W;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 2'd0,
		CMD_CLOSE = 2'd1,
		CMD_POP   = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_FULL  = 3'd2,
		ST_LONG  = 3'd3,
		ST_OPEN  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_TLEN  = 3'b010,
		S_BYTES = 3'b100
	} state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              has_byte;
		logic              last;
		status_t           status;
		logic [FILL_W-1:0] fill;
		logic [TLEN_W-1:0] top_length;
	} result_t;

endpackage

### rtl/vlrs_store.sv
// ----------------------------------------------------------------------------
// vlrs_store
// byte store of the record stack: one write port, one registered read port
// ----------------------------------------------------------------------------
module vlrs_store #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [vlrs_pkg::BYTE_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [vlrs_pkg::BYTE_W-1:0] rdata
);
	import vlrs_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/variable_length_record_stack_unit.sv
// ----------------------------------------------------------------------------
// variable_length_record_stack_unit
// byte-wide stack of variable-length records, each stored as its bytes and a
// trailing length byte; pops stream the top record back in original order
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+--------------------------------------
//   cfg      | in  | cfg_we            | cfg_wdata: capacity
//   s        | in  | s_tvalid/s_tready | s_tuser: cmd, s_tdata: data_byte
//   m        | out | m_tvalid/m_tready | m_tdata, m_tuser: has_byte, m_tlast
//
// push, close, clear and a failed pop load their result as they are accepted
// a pop of a record is accepted, then the new top length is read, then its bytes
//   leave one byte per cycle while the output is free (an empty record gives a
//   single result), all through the single read port of the byte store
// reset clears all control state; the byte store needs no clearing
// a stalled output holds the block; a new item is taken only in a cycle where
//   the output register is empty or its result transfers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module variable_length_record_stack_unit #(
	parameter int unsigned DEPTH   = 1024,
	parameter int unsigned MAX_LEN = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [vlrs_pkg::CAP_W-1:0]   cfg_wdata,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [vlrs_pkg::BYTE_W-1:0]  s_tdata,  // [7:0] data_byte
	input  logic [vlrs_pkg::CMD_W-1:0]   s_tuser,  // [1:0] cmd
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [vlrs_pkg::TDATA_W-1:0] m_tdata,  // [7:0] out_byte, [10:8] status,
	                                               // [21:11] fill, [28:22] top_length
	output logic                         m_tuser,  // [0] has_byte
	output logic                         m_tlast
);
	import vlrs_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned PW = $clog2(DEPTH + 1);
	localparam int unsigned CW = ((PW > CAP_W) ? PW : CAP_W) + 1;

	state_t            state_q, state_d;
	logic [CAP_W-1:0]  cap_q;
	logic [PW-1:0]     top_ptr_q, top_ptr_d;
	logic [PW-1:0]     rec_start_q, rec_start_d;
	logic [PW-1:0]     closed_cnt_q, closed_cnt_d;
	logic [BYTE_W-1:0] open_cnt_q, open_cnt_d;
	logic [BYTE_W-1:0] top_len_q, top_len_d;
	logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
	logic [BYTE_W-1:0] len_q, len_d;
	logic [BYTE_W-1:0] emit_cnt_q, emit_cnt_d;
	logic              out_valid_q;
	result_t           out_q;

	logic              out_free;
	logic              in_xfer;
	cmd_t              cmd;
	logic [CW-1:0]     cap_eff;
	logic [CW-1:0]     tp_w;
	logic [PW-1:0]     base;
	logic              out_load;
	result_t           res;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [BYTE_W-1:0] mem_rdata;
	logic              chk_ptr_order;
	logic              chk_no_rec;
	logic              chk_rec_clear;
	logic              chk_pop_last;

	// byte store
	vlrs_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// handshake and common terms
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign in_xfer  = s_tvalid && s_tready;
	assign cmd      = cmd_t'(s_tuser);
	assign cap_eff  = (CW'(cap_q) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_q);
	assign tp_w     = CW'(top_ptr_q);
	assign base     = rec_start_q - PW'(1) - PW'(top_len_q);

	// command decode and pop sequencer
	always_comb begin
		state_d      = state_q;
		top_ptr_d    = top_ptr_q;
		rec_start_d  = rec_start_q;
		closed_cnt_d = closed_cnt_q;
		open_cnt_d   = open_cnt_q;
		top_len_d    = top_len_q;
		rd_ptr_d     = rd_ptr_q;
		len_d        = len_q;
		emit_cnt_d   = emit_cnt_q;
		out_load     = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = top_ptr_q[AW-1:0];
		mem_wdata    = s_tdata;
		mem_re       = 1'b0;
		mem_raddr    = rd_ptr_q[AW-1:0];
		res.out_byte = '0;
		res.has_byte = 1'b0;
		res.last     = 1'b1;
		res.status   = ST_OK;

		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					unique case (cmd)
						CMD_PUSH: begin
							out_load = 1'b1;
							if (open_cnt_q >= BYTE_W'(MAX_LEN)) begin
								top_ptr_d  = rec_start_q;
								open_cnt_d = '0;
								res.status = ST_LONG;
							end else if (tp_w + CW'(2) > cap_eff) begin
								top_ptr_d  = rec_start_q;
								open_cnt_d = '0;
								res.status = ST_FULL;
							end else begin
								mem_we     = 1'b1;
								top_ptr_d  = top_ptr_q + PW'(1);
								open_cnt_d = open_cnt_q + BYTE_W'(1);
							end
						end
						CMD_CLOSE: begin
							out_load = 1'b1;
							if (tp_w + CW'(1) > cap_eff) begin
								top_ptr_d  = rec_start_q;
								open_cnt_d = '0;
								res.status = ST_FULL;
							end else begin
								mem_we       = 1'b1;
								mem_wdata    = open_cnt_q;
								top_ptr_d    = top_ptr_q + PW'(1);
								rec_start_d  = top_ptr_q + PW'(1);
								open_cnt_d   = '0;
								closed_cnt_d = closed_cnt_q + PW'(1);
								top_len_d    = open_cnt_q;
							end
						end
						CMD_CLEAR: begin
							out_load     = 1'b1;
							top_ptr_d    = '0;
							rec_start_d  = '0;
							open_cnt_d   = '0;
							closed_cnt_d = '0;
							top_len_d    = '0;
						end
						CMD_POP: begin
							priority if (open_cnt_q != '0) begin
								out_load   = 1'b1;
								res.status = ST_OPEN;
							end else if (closed_cnt_q == '0) begin
								out_load   = 1'b1;
								res.status = ST_EMPTY;
							end else begin
								// drop the record now, fetch the length below it
								top_ptr_d    = base;
								rec_start_d  = base;
								closed_cnt_d = closed_cnt_q - PW'(1);
								len_d        = top_len_q;
								emit_cnt_d   = '0;
								mem_re       = 1'b1;
								mem_raddr    = AW'(base - PW'(1));
								rd_ptr_d     = base;
								state_d      = S_TLEN;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_TLEN: begin
				// length byte of the record now on top
				top_len_d = (closed_cnt_q == '0) ? '0 : mem_rdata;
				if (len_q == '0) begin
					if (out_free) begin
						out_load = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					mem_re   = 1'b1;
					rd_ptr_d = rd_ptr_q + PW'(1);
					state_d  = S_BYTES;
				end
			end
			S_BYTES: begin
				// one record byte per transfer, next read issued as it leaves
				if (out_free) begin
					out_load     = 1'b1;
					res.out_byte = mem_rdata;
					res.has_byte = 1'b1;
					res.last     = (emit_cnt_q == len_q - BYTE_W'(1));
					if (res.last) begin
						state_d = S_IDLE;
					end else begin
						emit_cnt_d = emit_cnt_q + BYTE_W'(1);
						mem_re     = 1'b1;
						rd_ptr_d   = rd_ptr_q + PW'(1);
					end
				end
			end
			default: state_d = S_IDLE;
		endcase

		res.fill       = FILL_W'(top_ptr_d);
		res.top_length = TLEN_W'(top_len_d);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cap_q        <= CAP_RESET;
			top_ptr_q    <= '0;
			rec_start_q  <= '0;
			closed_cnt_q <= '0;
			open_cnt_q   <= '0;
			top_len_q    <= '0;
			rd_ptr_q     <= '0;
			len_q        <= '0;
			emit_cnt_q   <= '0;
		end else begin
			state_q      <= state_d;
			top_ptr_q    <= top_ptr_d;
			rec_start_q  <= rec_start_d;
			closed_cnt_q <= closed_cnt_d;
			open_cnt_q   <= open_cnt_d;
			top_len_q    <= top_len_d;
			rd_ptr_q     <= rd_ptr_d;
			len_q        <= len_d;
			emit_cnt_q   <= emit_cnt_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {PAD_W'(0), out_q.top_length, out_q.fill, out_q.status, out_q.out_byte};
	assign m_tuser  = out_q.has_byte;
	assign m_tlast  = out_q.last;

	// checks; the top length settles in S_TLEN after the last record is popped
	assign chk_ptr_order = (rec_start_q <= top_ptr_q) && (tp_w <= CW'(DEPTH));
	assign chk_no_rec    = (closed_cnt_q == '0) && (state_q != S_TLEN);
	assign chk_rec_clear = (rec_start_q == '0) && (top_len_q == '0);
	assign chk_pop_last  = (state_q == S_BYTES) && out_load && res.last;

	`VLRS_ASSERT(a_open_limit, clk, arst_n, open_cnt_q <= BYTE_W'(MAX_LEN), "open record too long")
	`VLRS_ASSERT(a_ptr_order, clk, arst_n, chk_ptr_order, "pointer order broken")
	`VLRS_ASSERT_IMP(a_no_records, clk, arst_n, chk_no_rec, chk_rec_clear, "stale top record")
	`VLRS_ASSERT_NXT(a_pop_end, clk, arst_n, chk_pop_last, state_q == S_IDLE, "pop not ended")

endmodule

### verif/variable_length_record_stack_unit_test.sv
// ----------------------------------------------------------------------------
// variable_length_record_stack_unit_test
// self-checking bench for the record stack: a queue-fed driver offers push,
// close, pop and clear commands, a predictor tracks the stack contents and
// queues the expected results, and a monitor compares every output transfer
// field by field; capacity is rewritten between phases while the block is idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module variable_length_record_stack_unit_test;
	import vlrs_pkg::*;

	localparam int unsigned STORE_DEPTH = 1024;
	localparam int unsigned REC_MAX     = 64;
	localparam int unsigned LEN_FIELD   = 256;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned POP_LATENCY = REC_MAX + 6;

	typedef struct {
		cmd_t       cmd;
		logic [7:0] data;
	} stack_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [BYTE_W-1:0] s_tdata = '0;  // [7:0] data_byte
	logic [CMD_W-1:0] s_tuser = '0;   // [1:0] cmd
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;      // [7:0] out_byte, [10:8] status,
	                                  // [21:11] fill, [28:22] top_length
	logic m_tuser;                    // [0] has_byte
	logic m_tlast;

	// commands waiting to be offered, and results the stack should produce
	stack_cmd_t cmd_queue[$];
	result_t pending_results[$];
	int unsigned error_count = 0;

	// idle rates in percent and the long receiver hold-off
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	logic hold_req = 1'b0;
	int unsigned hold_left = 0;

	// predicted stack state
	logic [7:0] mem_bytes [0:STORE_DEPTH-1];
	int unsigned stack_top = 0;
	int unsigned rec_end = 0;
	int unsigned open_len = 0;
	int unsigned rec_count = 0;
	int unsigned capacity_reg = CAP_RESET;

	variable_length_record_stack_unit #(
		.DEPTH(STORE_DEPTH),
		.MAX_LEN(REC_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// length byte of the topmost closed record
	function automatic logic [TLEN_W-1:0] top_record_len();
		if (rec_count == 0 || rec_end == 0 || rec_end > STORE_DEPTH)
			return '0;
		return mem_bytes[rec_end-1][TLEN_W-1:0];
	endfunction

	function automatic void queue_result(logic [7:0] b, logic has, logic fin, status_t st);
		result_t r;
		r.out_byte = b;
		r.has_byte = has;
		r.last = fin;
		r.status = st;
		r.fill = stack_top[FILL_W-1:0];
		r.top_length = top_record_len();
		pending_results.push_back(r);
	endfunction

	// advance the predicted stack by one command and queue its results
	function automatic void apply_stack_cmd(cmd_t cmd, logic [7:0] db);
		int unsigned room;
		int unsigned len;
		int unsigned base;
		status_t st;
		room = (capacity_reg > STORE_DEPTH) ? STORE_DEPTH : capacity_reg;
		st = ST_OK;
		case (cmd)
			CMD_PUSH: begin
				if (open_len >= REC_MAX) begin
					stack_top = rec_end;
					open_len = 0;
					st = ST_LONG;
				end else if (stack_top + 2 > room) begin
					stack_top = rec_end;
					open_len = 0;
					st = ST_FULL;
				end else begin
					mem_bytes[stack_top] = db;
					stack_top++;
					open_len++;
				end
				queue_result('0, 1'b0, 1'b1, st);
			end
			CMD_CLOSE: begin
				if (stack_top + 1 > room || open_len >= LEN_FIELD) begin
					stack_top = rec_end;
					open_len = 0;
					st = ST_FULL;
				end else begin
					mem_bytes[stack_top] = open_len[7:0];
					stack_top++;
					rec_end = stack_top;
					open_len = 0;
					rec_count++;
				end
				queue_result('0, 1'b0, 1'b1, st);
			end
			CMD_CLEAR: begin
				stack_top = 0;
				rec_end = 0;
				open_len = 0;
				rec_count = 0;
				queue_result('0, 1'b0, 1'b1, ST_OK);
			end
			default: begin
				if (open_len != 0) begin
					queue_result('0, 1'b0, 1'b1, ST_OPEN);
				end else if (rec_count == 0 || rec_end == 0 || rec_end > STORE_DEPTH) begin
					queue_result('0, 1'b0, 1'b1, ST_EMPTY);
				end else begin
					len = mem_bytes[rec_end-1];
					if (len > rec_end - 1)
						len = rec_end - 1;
					if (len > REC_MAX)
						len = REC_MAX;
					base = rec_end - 1 - len;
					stack_top = base;
					rec_end = base;
					rec_count--;
					// the store is untouched by a pop, so bytes are read after the update
					if (len == 0)
						queue_result('0, 1'b0, 1'b1, ST_OK);
					else
						for (int unsigned i = 0; i < len; i++)
							queue_result(mem_bytes[base+i], 1'b1, i + 1 == len, ST_OK);
				end
			end
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch: %s", msg);
		error_count++;
	endtask

	task automatic check_field(string field, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d, expected %0d", field, got, want));
	endtask

	// driver: offer queued commands, predict each accepted transfer
	always @(posedge clk or negedge arst_n) begin
		stack_cmd_t item;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				apply_stack_cmd(cmd_t'(s_tuser), s_tdata);
			if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item = cmd_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= item.cmd;
				s_tdata <= item.data;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_req)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// monitor: check each output transfer against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result, tdata %h", m_tdata));
				end else begin
					want = pending_results.pop_front();
					check_field("out_byte", m_tdata[7:0], want.out_byte);
					check_field("has_byte", m_tuser, want.has_byte);
					check_field("last", m_tlast, want.last);
					check_field("status", m_tdata[10:8], want.status);
					check_field("fill", m_tdata[21:11], want.fill);
					check_field("top_length", m_tdata[28:22], want.top_length);
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic add_cmd(cmd_t cmd, logic [7:0] data);
		stack_cmd_t item;
		item.cmd = cmd;
		item.data = data;
		cmd_queue.push_back(item);
	endtask

	// a record of random bytes followed by its close
	task automatic add_record(int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			add_cmd(CMD_PUSH, 8'($urandom));
		add_cmd(CMD_CLOSE, 8'($urandom));
	endtask

	// mostly whole records and pops, some noise and broken records
	task automatic add_random_traffic(int unsigned count);
		int unsigned added;
		int unsigned pick;
		int unsigned len;
		added = 0;
		while (added < count) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				len = ($urandom_range(7) == 0) ? $urandom_range(REC_MAX) : $urandom_range(5);
				add_record(len);
				added += len + 1;
				if ($urandom_range(1)) begin
					add_cmd(CMD_POP, 8'($urandom));
					added++;
				end
			end else if (pick < 78) begin
				add_cmd(CMD_POP, 8'($urandom));
				added++;
			end else if (pick < 90) begin
				add_cmd(cmd_t'($urandom_range(3)), 8'($urandom));
				added++;
			end else begin
				// pop against an open record, then close or abandon it
				len = $urandom_range(1, 4);
				for (int unsigned i = 0; i < len; i++)
					add_cmd(CMD_PUSH, 8'($urandom));
				add_cmd(CMD_POP, 8'($urandom));
				add_cmd($urandom_range(1) ? CMD_CLOSE : CMD_CLEAR, 8'($urandom));
				added += len + 2;
			end
		end
	endtask

	// sender holds back until every command is taken and every result is in
	task automatic drain();
		while (cmd_queue.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value[CAP_W-1:0];
		capacity_reg = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_idle(int unsigned send_pct, int unsigned recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	// run limit
	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	// stimulus sequence
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// basic commands at full capacity
		set_idle(37, 72);
		write_capacity(CAP_RESET);
		add_cmd(CMD_POP, 8'h00);
		add_cmd(CMD_CLOSE, 8'h00);
		add_cmd(CMD_POP, 8'hFF);
		add_cmd(CMD_PUSH, 8'h00);
		add_cmd(CMD_PUSH, 8'hFF);
		add_cmd(CMD_POP, 8'h00);
		add_cmd(CMD_PUSH, 8'hA5);
		add_cmd(CMD_CLOSE, 8'hFF);
		add_cmd(CMD_CLOSE, 8'h00);
		add_cmd(CMD_POP, 8'h00);
		add_cmd(CMD_POP, 8'h00);
		add_cmd(CMD_POP, 8'h00);
		add_cmd(CMD_PUSH, 8'h5A);
		add_cmd(CMD_CLEAR, 8'hFF);
		add_cmd(CMD_POP, 8'h00);
		drain();

		// capacity of two: one byte and a length byte at most
		write_capacity(2);
		add_cmd(CMD_PUSH, 8'h11);
		add_cmd(CMD_PUSH, 8'h22);
		add_cmd(CMD_CLOSE, 8'h00);
		add_cmd(CMD_CLOSE, 8'h00);
		add_cmd(CMD_CLOSE, 8'h00);
		add_cmd(CMD_PUSH, 8'h33);
		add_cmd(CMD_POP, 8'h00);
		add_cmd(CMD_POP, 8'h00);
		add_cmd(CMD_POP, 8'h00);
		drain();

		// capacity lowered below the fill: held data stays, new data is refused
		write_capacity(1023);
		add_record(2);
		add_record(1);
		drain();
		write_capacity(4);
		add_cmd(CMD_PUSH, 8'h77);
		add_cmd(CMD_CLOSE, 8'h00);
		add_cmd(CMD_POP, 8'h00);
		add_cmd(CMD_PUSH, 8'h88);
		add_cmd(CMD_POP, 8'h00);
		add_cmd(CMD_CLEAR, 8'h00);
		drain();

		// random traffic, sender mostly idle, small capacity so long records can overflow
		set_idle(72, 37);
		write_capacity($urandom_range(16, 200));
		add_random_traffic(10);
		drain();

		// one byte past the length limit while the receiver holds off
		set_idle(0, 0);
		write_capacity(CAP_RESET);
		@(posedge clk);
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		add_cmd(CMD_CLEAR, 8'h00);
		for (int unsigned i = 0; i <= REC_MAX; i++)
			add_cmd(CMD_PUSH, 8'($urandom));
		add_cmd(CMD_CLOSE, 8'h00);
		add_cmd(CMD_POP, 8'h00);
		drain();

		// random traffic with no idling
		write_capacity($urandom_range(64, 1024));
		add_random_traffic(8);
		drain();

		repeat (POP_LATENCY) @(posedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/vlrs_pkg.sv
rtl/vlrs_store.sv
rtl/variable_length_record_stack_unit.sv
verif/variable_length_record_stack_unit_test.sv
